// ===== design/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  // Fixed field widths of the item formats.
  localparam int SYM_W       = 8;
  localparam int CODE_W      = 32;
  localparam int LEN_FIELD_W = 6;
  localparam int BYTE_W      = 8;

  // Leftover bits never reach a full byte, so at most seven wait.
  localparam int PEND_W = BYTE_W - 1;
  // Bit accumulator: leftover bits followed by the widest code.
  localparam int ACC_W  = PEND_W + CODE_W;
  // Bit count of the accumulator, 0 to ACC_W.
  localparam int TOT_W  = $clog2(ACC_W + 1);

  // Defaults for the top level parameters.
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Operation codes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  // One input item.
  typedef struct packed {
    logic                   operation;
    logic [SYM_W-1:0]       symbol;
    logic [CODE_W-1:0]      code_bits;
    logic [LEN_FIELD_W-1:0] code_length;
    logic                   final_symbol;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              stream_end;
  } out_item_t;

  // A looked-up symbol waiting for the packer: code left-aligned.
  typedef struct packed {
    logic [CODE_W-1:0]      code_la;
    logic [LEN_FIELD_W-1:0] len;
    logic                   fin;
  } sym_entry_t;

  // Fill status of the symbol queue.
  typedef struct packed {
    logic full;
    logic almost_full;
    logic nonempty;
  } q_status_t;

endpackage

// ===== design/hcbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/hcbp_front.sv =====
// Front end: accepts items, writes the code table and looks up encoded symbols.
module hcbp_front #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hcbp_pkg::in_item_t   in_data,
  input  hcbp_pkg::q_status_t  q_status,
  output logic                 push,
  output hcbp_pkg::sym_entry_t push_entry
);

  localparam int LEN_LIMIT = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : hcbp_pkg::CODE_W;
  localparam int LEN_W     = $clog2(LEN_LIMIT + 1);
  localparam int ENTRY_W   = hcbp_pkg::CODE_W + LEN_W;
  localparam int ADDR_W    = $clog2(SYMBOL_COUNT);

  logic                             accept;
  logic                             in_range;
  logic                             load_we;
  logic [hcbp_pkg::LEN_FIELD_W-1:0] len_clamped;
  logic [ENTRY_W-1:0]               wdata;
  logic [ENTRY_W-1:0]               rdata;
  logic                             rd_valid_r;
  logic                             rd_valid_nxt;
  logic                             rd_fin_r;
  logic                             rd_in_range_r;
  logic [hcbp_pkg::LEN_FIELD_W-1:0] rd_len;
  logic [hcbp_pkg::LEN_FIELD_W-1:0] rd_shamt;

  // Stall while the queue could not take every lookup already in flight.
  assign in_stall = q_status.full || (q_status.almost_full && rd_valid_r);
  assign accept   = in_valid && !in_stall;
  assign in_range = {1'b0, in_data.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);

  // Table load: clamp the length to the supported bound.
  assign load_we     = accept && (in_data.operation == hcbp_pkg::OP_LOAD) && in_range;
  assign len_clamped = (in_data.code_length > hcbp_pkg::LEN_FIELD_W'(LEN_LIMIT))
                       ? hcbp_pkg::LEN_FIELD_W'(LEN_LIMIT) : in_data.code_length;
  assign wdata       = {len_clamped[LEN_W-1:0], in_data.code_bits};

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_data.symbol[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (in_data.symbol[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Lookup in flight: the table answers in the cycle after the transfer.
  assign rd_valid_nxt = accept && (in_data.operation == hcbp_pkg::OP_ENCODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid_nxt) begin
      rd_fin_r      <= in_data.final_symbol;
      rd_in_range_r <= in_range;
    end
  end

  // Out-of-range symbols contribute no bits; left-align the code for the packer.
  assign rd_len   = rd_in_range_r ? hcbp_pkg::LEN_FIELD_W'(rdata[hcbp_pkg::CODE_W +: LEN_W])
                                  : '0;
  assign rd_shamt = hcbp_pkg::LEN_FIELD_W'(hcbp_pkg::CODE_W) - rd_len;

  assign push               = rd_valid_r;
  assign push_entry.code_la = rdata[hcbp_pkg::CODE_W-1:0] << rd_shamt;
  assign push_entry.len     = rd_len;
  assign push_entry.fin     = rd_fin_r;

`ifndef NO_ASSERTIONS
  // A completed lookup always finds room in the queue.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> !q_status.full)
    else $error("lookup completed into a full queue");
`endif

endmodule

// ===== design/hcbp_queue.sv =====
// Short queue of looked-up symbols between the front end and the packer.
module hcbp_queue #(
  parameter int DEPTH = hcbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hcbp_pkg::sym_entry_t push_entry,
  input  logic                 pop,
  output hcbp_pkg::sym_entry_t pop_entry,
  output hcbp_pkg::q_status_t  q_status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hcbp_pkg::sym_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;

  // Pointer advance with wrap at the last slot.
  assign wr_ptr_nxt = !push ? wr_ptr_r
                    : (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = !pop ? rd_ptr_r
                    : (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry            = mem_r[rd_ptr_r];
  assign q_status.full        = (count_r == CNT_W'(DEPTH));
  assign q_status.almost_full = (count_r >= CNT_W'(DEPTH - 1));
  assign q_status.nonempty    = (count_r != '0);

`ifndef NO_ASSERTIONS
  // No write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CNT_W'(DEPTH)))
    else $error("queue overflow");

  // No read from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue underflow");
`endif

endmodule

// ===== design/hcbp_back.sv =====
// Packer: appends codes to the bit accumulator and sends out completed bytes.
module hcbp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hcbp_pkg::q_status_t  q_status,
  input  hcbp_pkg::sym_entry_t pop_entry,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hcbp_pkg::out_item_t  out_data
);

  // Accumulator is left-aligned: the next bit to send sits in the MSB and
  // all bits below the count are zero.
  logic [hcbp_pkg::ACC_W-1:0]  work_r;
  logic [hcbp_pkg::ACC_W-1:0]  work_nxt;
  logic [hcbp_pkg::TOT_W-1:0]  total_r;
  logic [hcbp_pkg::TOT_W-1:0]  total_nxt;
  logic                        fin_r;
  logic                        fin_nxt;
  logic                        busy_r;
  logic                        busy_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  hcbp_pkg::out_item_t         out_data_r;
  logic                        full_byte;
  logic                        needs_emit;
  logic                        can_load_out;
  logic                        emit;
  logic                        emit_end;
  logic                        done;
  logic                        clear_pend;
  logic [hcbp_pkg::ACC_W-1:0]  base_work;
  logic [2:0]                  base_cnt;
  logic [hcbp_pkg::ACC_W-1:0]  merged;

  // Work left on the current symbol.
  assign full_byte    = (total_r >= hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));
  assign needs_emit   = full_byte || (fin_r && (total_r != '0));
  assign can_load_out = !out_valid_r || !out_stall;
  assign emit         = busy_r && needs_emit && can_load_out;
  assign emit_end     = fin_r && (total_r <= hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));
  assign done         = busy_r && !needs_emit;
  assign clear_pend   = done && fin_r;

  // Next symbol may enter in the same cycle the current one finishes.
  assign pop = q_status.nonempty && (!busy_r || done);

  // Leftover bits that the next code is appended to.
  assign base_work = clear_pend ? '0 : work_r;
  assign base_cnt  = clear_pend ? 3'd0 : total_r[2:0];
  assign merged    = base_work | ({pop_entry.code_la, {hcbp_pkg::PEND_W{1'b0}}} >> base_cnt);

  always_comb begin
    work_nxt  = work_r;
    total_nxt = total_r;
    fin_nxt   = fin_r;
    busy_nxt  = busy_r;
    if (emit) begin
      work_nxt  = work_r << hcbp_pkg::BYTE_W;
      total_nxt = full_byte ? total_r - hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W) : '0;
    end else if (pop) begin
      work_nxt  = merged;
      total_nxt = hcbp_pkg::TOT_W'(base_cnt) + hcbp_pkg::TOT_W'(pop_entry.len);
      fin_nxt   = pop_entry.fin;
      busy_nxt  = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
      if (fin_r) begin
        work_nxt  = '0;
        total_nxt = '0;
      end
    end
  end

  // Output register: holds a byte until the transfer completes.
  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r      <= '0;
      total_r     <= '0;
      fin_r       <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      work_r      <= work_nxt;
      total_r     <= total_nxt;
      fin_r       <= fin_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.packed_byte <= work_r[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_W];
      out_data_r.stream_end  <= emit_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Between symbols only a partial byte may wait.
  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (total_r < hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W)))
    else $error("idle packer holds a full byte");

  // The end byte leaves the accumulator empty.
  a_end_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_end) |=> (total_r == '0))
    else $error("bits left after the end byte");
`endif

endmodule

// ===== design/huffman_code_bit_packer.sv =====
// Huffman code bit packer: a code table lookup front end, a symbol queue
// and a byte packer. Load transfers write one code table entry when the
// symbol is in range. An encoded symbol is looked up in the table (registered
// RAM read), queued, and then packed: the packer takes in a symbol and then
// sends each byte the symbol completes, so when the output is not stalled a
// stream runs near one symbol per cycle while codes are short and at one byte
// per cycle when bytes complete; the single byte output register sets that
// limit. Results pass through the registered table read, the symbol queue,
// the packer accumulator and the output register. Input stall rises when
// the symbol queue is full, or one slot short of full while a lookup is still
// in flight. A code table entry must be loaded before it is used for encoding.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hcbp_pkg::out_item_t out_data
);

  hcbp_pkg::q_status_t  q_status;
  logic                 push;
  hcbp_pkg::sym_entry_t push_entry;
  logic                 pop;
  hcbp_pkg::sym_entry_t pop_entry;

  hcbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  hcbp_queue #(
    .DEPTH (hcbp_pkg::QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_status   (q_status)
  );

  hcbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
